FILE: design/single_word_extended_gcd_assert.svh
// Assertion macros for the extended gcd block
`ifndef SINGLE_WORD_EXTENDED_GCD_ASSERT_SVH
`define SINGLE_WORD_EXTENDED_GCD_ASSERT_SVH
// implication checked each clock outside reset
`define SWEG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SWEG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: design/sweg_pkg.sv
// ----------------------------------------------------------------------------
// sweg_pkg
// Shared types for the extended gcd controller and datapath.
// ----------------------------------------------------------------------------
package sweg_pkg;
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STEP,
        CMD_DIV_START,
        CMD_DIV_ITER,
        CMD_DIV_APPLY
    } t_cmd;

    typedef struct packed {
        logic rb_zero;
        logic rb_next;
        logic small_q;
        logic div_done;
    } t_status;
endpackage

FILE: design/sweg_dp.sv
// ----------------------------------------------------------------------------
// sweg_dp
// Remainder and cofactor registers with a subtraction step, a restoring
// divider and a serial quotient multiplier.
// ----------------------------------------------------------------------------
module sweg_dp #(
    parameter int W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sweg_pkg::t_cmd    i_cmd,
    input  logic [W-1:0]      i_x,
    input  logic [W-1:0]      i_y,
    output sweg_pkg::t_status o_status,
    output logic [W-1:0]      o_ra,
    output logic [W-1:0]      o_sa,
    output logic [W-1:0]      o_ta
);
    import sweg_pkg::*;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_ra, r_rb, r_sa, r_sb, r_ta, r_tb;
    logic [W-1:0]  r_q, r_rem, r_num, r_ps, r_pt;
    logic [CW-1:0] r_cnt;
    logic          r_mul;
    logic [W-1:0]  d, rb2, rb4, qsb, qtb, r_s;
    logic [W:0]    trial;
    logic [W-1:0]  rem_sh;

    always_comb begin
        d   = r_ra - r_rb;
        rb2 = {r_rb[W-2:0], 1'b0};
        rb4 = {r_rb[W-3:0], 2'b00};
        if (d < r_rb) begin
            qsb = r_sb;
            qtb = r_tb;
            r_s = d;
        end else if (d < rb2) begin
            qsb = {r_sb[W-2:0], 1'b0};
            qtb = {r_tb[W-2:0], 1'b0};
            r_s = d - r_rb;
        end else begin
            qsb = r_sb + {r_sb[W-2:0], 1'b0};
            qtb = r_tb + {r_tb[W-2:0], 1'b0};
            r_s = d - rb2;
        end
        rem_sh = {r_rem[W-2:0], r_num[W-1]};
        trial  = {r_rem[W-1], rem_sh} - {1'b0, r_rb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_mul <= 1'b0;
        end else begin
            unique case (i_cmd)
                CMD_LOAD: begin
                    if (i_y > i_x) begin
                        r_ra <= i_y; r_rb <= i_x;
                        r_sa <= '0;  r_sb <= W'(1);
                        r_ta <= W'(1); r_tb <= '0;
                    end else begin
                        r_ra <= i_x; r_rb <= i_y;
                        r_sa <= W'(1); r_sb <= '0;
                        r_ta <= '0;  r_tb <= W'(1);
                    end
                    if (i_x[W-1] && i_y[W-1]) begin
                        r_ra <= (i_y > i_x) ? i_x : i_y;
                        r_rb <= (i_y > i_x) ? i_y - i_x : i_x - i_y;
                        r_sa <= (i_y > i_x) ? W'(1) : '0;
                        r_sb <= (i_y > i_x) ? '1 : W'(1);
                        r_ta <= (i_y > i_x) ? '0 : W'(1);
                        r_tb <= (i_y > i_x) ? W'(1) : '1;
                    end
                end
                CMD_STEP: begin
                    r_ra <= r_rb; r_rb <= r_s;
                    r_sa <= r_sb; r_sb <= r_sa - qsb;
                    r_ta <= r_tb; r_tb <= r_ta - qtb;
                end
                CMD_DIV_START: begin
                    r_num <= r_ra; r_rem <= '0; r_q <= '0;
                    r_cnt <= CW'(W); r_mul <= 1'b0;
                end
                CMD_DIV_ITER: begin
                    if (!r_mul) begin
                        r_num <= {r_num[W-2:0], 1'b0};
                        if (!trial[W]) begin
                            r_rem <= trial[W-1:0]; r_q <= {r_q[W-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh; r_q <= {r_q[W-2:0], 1'b0};
                        end
                        if (r_cnt == CW'(1)) begin
                            r_mul <= 1'b1; r_cnt <= CW'(W);
                            r_ps <= '0; r_pt <= '0;
                        end else begin
                            r_cnt <= r_cnt - CW'(1);
                        end
                    end else begin
                        r_ps <= {r_ps[W-2:0], 1'b0} + (r_q[W-1] ? r_sb : '0);
                        r_pt <= {r_pt[W-2:0], 1'b0} + (r_q[W-1] ? r_tb : '0);
                        r_q  <= {r_q[W-2:0], 1'b0};
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                CMD_DIV_APPLY: begin
                    r_ra <= r_rb; r_rb <= r_rem;
                    r_sa <= r_sb; r_sb <= r_sa - r_ps;
                    r_ta <= r_tb; r_tb <= r_ta - r_pt;
                    r_mul <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_status.rb_zero  = (r_rb == '0);
    assign o_status.rb_next  = r_rb[W-2];
    assign o_status.small_q  = (r_ra < rb4);
    assign o_status.div_done = r_mul && (r_cnt == '0);
    assign o_ra = r_ra;
    assign o_sa = r_sa;
    assign o_ta = r_ta;
endmodule

FILE: design/sweg_ctrl.sv
// ----------------------------------------------------------------------------
// sweg_ctrl
// Sequencer for the gcd steps and the output register handshake.
// ----------------------------------------------------------------------------
`include "single_word_extended_gcd_assert.svh"
module sweg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  sweg_pkg::t_status i_status,
    output sweg_pkg::t_cmd    o_cmd,
    output logic              o_capture
);
    import sweg_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_HIGH, S_LOW, S_DIV, S_DONE} t_state;
    t_state r_state, n_state;
    logic   r_ovalid;

    always_comb begin
        n_state   = r_state;
        o_cmd     = CMD_NONE;
        o_capture = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd = CMD_LOAD; n_state = S_HIGH;
            end
            S_HIGH: begin
                if (i_status.rb_next) o_cmd = CMD_STEP;
                else n_state = S_LOW;
            end
            S_LOW: begin
                if (i_status.rb_zero) n_state = S_DONE;
                else if (i_status.small_q) o_cmd = CMD_STEP;
                else begin
                    o_cmd = CMD_DIV_START; n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd = CMD_DIV_APPLY; n_state = S_LOW;
                end else o_cmd = CMD_DIV_ITER;
            end
            S_DONE: if (!r_ovalid || !i_stall) begin
                o_capture = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_capture) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    `SWEG_ASSERT_IMP(a_cap_done, o_capture, r_state == S_DONE)
    `SWEG_ASSERT_NXT(a_valid_hold, o_valid && i_stall, o_valid)
    `SWEG_ASSERT_IMP(a_load_idle, o_cmd == CMD_LOAD, r_state == S_IDLE && i_valid)
endmodule

FILE: design/single_word_extended_gcd.sv
// ----------------------------------------------------------------------------
// single_word_extended_gcd
// Extended gcd of two words with cofactors, g = a*x - b*y.
// Throughput: one transaction at a time; a new one enters after the result
// has moved to the output register. Set by the shared divider and multiplier.
// Reset: synchronous active low, clears sequencer and output valid.
// ----------------------------------------------------------------------------
module single_word_extended_gcd #(
    parameter int WORD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_x,
    input  logic [63:0] i_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_gcd,
    output logic signed [63:0] o_coef_a,
    output logic signed [63:0] o_coef_b
);
    import sweg_pkg::*;
    t_cmd    cmd;
    t_status status;
    logic    capture;
    logic [WORD_BITS-1:0] ra, sa, ta, tneg;
    logic [63:0] r_gcd, r_a, r_b;

    sweg_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_status(status), .o_cmd(cmd), .o_capture(capture)
    );

    sweg_dp #(.W(WORD_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_x(i_x[WORD_BITS-1:0]), .i_y(i_y[WORD_BITS-1:0]),
        .o_status(status), .o_ra(ra), .o_sa(sa), .o_ta(ta)
    );

    assign tneg = '0 - ta;

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_gcd <= 64'(ra);
            r_a   <= 64'(signed'(sa));
            r_b   <= 64'(signed'(tneg));
        end
    end

    assign o_gcd    = r_gcd;
    assign o_coef_a = r_a;
    assign o_coef_b = r_b;
endmodule

FILE: test/single_word_extended_gcd_tb.sv
// ----------------------------------------------------------------------------
// single_word_extended_gcd_tb
// Self-checking bench for the extended gcd block. Operand pairs are driven
// from a queue with random sender and receiver gaps. Every result is compared
// with an in-bench prediction of gcd and cofactors.
// ----------------------------------------------------------------------------
module single_word_extended_gcd_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = 64;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        logic [63:0] x;
        logic [63:0] y;
    } t_pair;

    typedef struct {
        logic [63:0] g;
        logic [63:0] a;
        logic [63:0] b;
    } t_gcd_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_x;
    logic [63:0] i_y;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_gcd;
    logic signed [63:0] o_coef_a;
    logic signed [63:0] o_coef_b;

    t_pair    pending_pairs[$];
    t_gcd_res expected_gcds[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_cycles;
    int       idle_count;
    int       n_fail;
    int       n_checked;
    int       n_sent;
    bit       in_taken;

    single_word_extended_gcd #(.WORD_BITS(WORD_BITS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_x     (i_x),
        .i_y     (i_y),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_gcd   (o_gcd),
        .o_coef_a(o_coef_a),
        .o_coef_b(o_coef_b)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_gcd_res ext_gcd(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] ra, rb, sa, sb, ta, tb, q, r, d, ns, nt;
        t_gcd_res res;
        ra = x; rb = y; sa = 1; sb = 0; ta = 0; tb = 1;
        if (y > x) begin
            ra = y; rb = x; sa = 0; sb = 1; ta = 1; tb = 0;
        end
        if (x[63] && y[63]) begin
            q = 1; r = ra - rb;
            ns = sa - q * sb; nt = ta - q * tb;
            sa = sb; sb = ns; ta = tb; tb = nt; ra = rb; rb = r;
        end
        while (rb != 0) begin
            if (rb[62] || ra < (rb << 2)) begin
                d = ra - rb;
                if (d < rb) begin
                    q = 1; r = d;
                end else if (d < (rb << 1)) begin
                    q = 2; r = d - rb;
                end else begin
                    q = 3; r = d - (rb << 1);
                end
            end else begin
                q = ra / rb; r = ra - q * rb;
            end
            ns = sa - q * sb; nt = ta - q * tb;
            sa = sb; sb = ns; ta = tb; tb = nt; ra = rb; rb = r;
        end
        res.g = ra; res.a = sa; res.b = 64'd0 - ta;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = v | 64'h8000_0000_0000_0000;
            2: v = {2'b01, v[61:0]};
            3: v = v & ~(64'hFFFF_FFFF_FFFF_FFFF << $urandom_range(1, 20));
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_pair(input logic [63:0] x, input logic [63:0] y);
        t_pair p;
        p.x = x; p.y = y;
        pending_pairs.push_back(p);
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || i_valid || expected_gcds.size() != 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_x <= pending_pairs[0].x;
                i_y <= pending_pairs[0].y;
                i_valid <= 1'b1;
                void'(pending_pairs.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_gcd_res e;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (in_taken) begin
                expected_gcds.push_back(ext_gcd(i_x, i_y));
                n_sent++;
            end
            if (in_taken || (o_valid && !i_stall)) begin
                idle_count <= 0;
            end else begin
                idle_count <= idle_count + 1;
            end
            if (o_valid && !i_stall) begin
                if (expected_gcds.size() == 0) begin
                    $display("%0t: unexpected result gcd=%h", $time, o_gcd);
                    n_fail++;
                end else begin
                    e = expected_gcds.pop_front();
                    n_checked++;
                    if (o_gcd !== e.g || o_coef_a !== e.a || o_coef_b !== e.b) begin
                        $display("%0t: expected g=%h a=%h b=%h actual g=%h a=%h b=%h",
                                 $time, e.g, e.a, e.b, o_gcd, o_coef_a, o_coef_b);
                        n_fail++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_count >= IDLE_LIMIT) begin
            $display("single_word_extended_gcd: mismatch");
            $finish;
        end
    end

    initial begin
        logic [63:0] m;
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_x = '0; i_y = '0;
        send_idle_pct = 24; recv_idle_pct = 49;
        hold_cycles = 0; idle_count = 0; n_fail = 0; n_checked = 0; n_sent = 0;
        m = 64'hFFFF_FFFF_FFFF_FFFF;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed corners
        add_pair(0, 0); add_pair(0, 5); add_pair(7, 0); add_pair(m, m);
        add_pair(m, m - 1); add_pair(m, 1); add_pair(1, m); add_pair(m, 0);
        add_pair(64'h8000_0000_0000_0000, 64'hC000_0000_0000_0001);
        add_pair(64'h4000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        add_pair(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFB);
        add_pair(12, 18); add_pair(m, 3); add_pair(m, 2); add_pair(100, 7);
        add_pair(64'hB504_F333_F9DE_6484, 64'h9E37_79B9_7F4A_7C15);
        add_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        for (int i = 0; i < 180; i++) add_pair(rand64(), rand64());

        // long receiver hold while the sender keeps offering
        @(negedge i_clk) hold_cycles = 300;
        for (int i = 0; i < 20; i++) add_pair(rand64(), rand64());
        wait_drained();

        send_idle_pct = 49; recv_idle_pct = 24;
        for (int i = 0; i < 170; i++) add_pair(rand64(), rand64());
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 170; i++) add_pair(rand64(), rand64());
        wait_drained();
        repeat (300) @(posedge i_clk);

        $display("Covered %0d operand pairs, %0d results checked, zero and top-bit corners",
                 n_sent, n_checked);
        $display("across three sender/receiver gap profiles and a long output hold.");
        if (n_fail == 0 && expected_gcds.size() == 0) begin
            $display("single_word_extended_gcd: match");
        end else begin
            $display("single_word_extended_gcd: mismatch");
        end
        $finish;
    end
endmodule
